### hdl/feal4_pkg.sv
`default_nettype none

package feal4_pkg;

  localparam int unsigned NumRounds = 4;
  localparam int unsigned NumKeys   = 6;
  localparam int unsigned KeyIdxW   = 3;

  localparam logic [KeyIdxW-1:0] KEY_IDX_ROUND_0 = 3'd0;
  localparam logic [KeyIdxW-1:0] KEY_IDX_ROUND_1 = 3'd1;
  localparam logic [KeyIdxW-1:0] KEY_IDX_ROUND_2 = 3'd2;
  localparam logic [KeyIdxW-1:0] KEY_IDX_ROUND_3 = 3'd3;
  localparam logic [KeyIdxW-1:0] KEY_IDX_WHITE_L = 3'd4;
  localparam logic [KeyIdxW-1:0] KEY_IDX_WHITE_R = 3'd5;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  // The word a goes through the round function, b is xored with its output.
  typedef struct packed {
    logic        valid;
    logic        cmd;
    logic [31:0] a;
    logic [31:0] b;
  } stage_t;

  function automatic logic [7:0] rot2(input logic [7:0] v);
    rot2 = {v[5:0], v[7:6]};
  endfunction

  function automatic logic [7:0] g_box(input logic [7:0] u, input logic [7:0] v,
                                       input logic carry);
    g_box = rot2(u + v + {7'd0, carry});
  endfunction

  function automatic logic [31:0] round_fn(input logic [31:0] w);
    logic [7:0] x0;
    logic [7:0] x1;
    logic [7:0] x2;
    logic [7:0] x3;
    logic [7:0] b;
    logic [7:0] y0;
    logic [7:0] y1;
    logic [7:0] y2;
    logic [7:0] y3;
    x0 = w[31:24];
    x1 = w[23:16];
    x2 = w[15:8];
    x3 = w[7:0];
    b  = x2 ^ x3;
    y1 = g_box(x0 ^ x1, b, 1'b1);
    y0 = g_box(x0, y1, 1'b0);
    y2 = g_box(y1, b, 1'b0);
    y3 = g_box(y2, x3, 1'b1);
    round_fn = {y0, y1, y2, y3};
  endfunction

endpackage

`default_nettype wire

### hdl/feal4_round_cell.sv
`default_nettype none

module feal4_round_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire feal4_pkg::stage_t stage_i,
  input  wire logic [31:0]      enc_key_i,
  input  wire logic [31:0]      dec_key_i,
  output feal4_pkg::stage_t     stage_o
);
  import feal4_pkg::*;

  logic        valid_q;
  logic        cmd_q;
  logic [31:0] a_q;
  logic [31:0] b_q;
  logic [31:0] a_d;
  logic [31:0] key;

  // Encryption and decryption share one round form once the halves are ordered
  // so that a always feeds the round function.
  always_comb begin
    key = (stage_i.cmd == CMD_DECRYPT) ? dec_key_i : enc_key_i;
    a_d = stage_i.b ^ round_fn(stage_i.a ^ key);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= stage_i.cmd;
    a_q   <= a_d;
    b_q   <= stage_i.a;
  end

  assign stage_o = '{valid: valid_q, cmd: cmd_q, a: a_q, b: b_q};

endmodule

`default_nettype wire

### hdl/feal4_block_cipher.sv
// Channel        | Ports                                      | Direction
// ---------------+--------------------------------------------+----------
// command        | start_i, busy_o, cmd_i, block_hi_i,        | in
//                | block_lo_i                                 |
// result         | done_o, result_hi_o, result_lo_o           | out
// configuration  | cfg_we_i, cfg_idx_i, cfg_data_i            | in
//
// One block is taken every cycle; busy_o stays low.
// Each result passes one pre-mix register, four round cells and the output
// register. Encryption whitens at the output register, decryption at the pre-mix.
// done_o marks each result for exactly one cycle and the receiver cannot stall.
// Reset clears the subkeys to zero and empties the pipeline.
`default_nettype none

module feal4_block_cipher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        cmd_i,
  input  wire logic [31:0] block_hi_i,
  input  wire logic [31:0] block_lo_i,
  output logic             done_o,
  output logic [31:0]      result_hi_o,
  output logic [31:0]      result_lo_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  import feal4_pkg::*;

  logic [31:0] key_q [NumKeys];
  stage_t      stg [NumRounds+1];
  logic        pre_valid_q;
  logic        pre_cmd_q;
  logic [31:0] pre_a_q;
  logic [31:0] pre_b_q;
  logic [31:0] pre_a_d;
  logic [31:0] pre_b_d;
  logic        out_valid_q;
  logic [31:0] out_hi_q;
  logic [31:0] out_lo_q;
  logic [31:0] out_hi_d;
  logic [31:0] out_lo_d;
  logic        accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumKeys; k++) begin
        key_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        KEY_IDX_ROUND_0: key_q[0] <= cfg_data_i;
        KEY_IDX_ROUND_1: key_q[1] <= cfg_data_i;
        KEY_IDX_ROUND_2: key_q[2] <= cfg_data_i;
        KEY_IDX_ROUND_3: key_q[3] <= cfg_data_i;
        KEY_IDX_WHITE_L: key_q[4] <= cfg_data_i;
        KEY_IDX_WHITE_R: key_q[5] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cmd_i == CMD_DECRYPT) begin
      pre_b_d = block_hi_i ^ key_q[4];
      pre_a_d = pre_b_d ^ block_lo_i ^ key_q[5];
    end else begin
      pre_b_d = block_hi_i;
      pre_a_d = block_hi_i ^ block_lo_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else begin
      pre_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    pre_cmd_q <= cmd_i;
    pre_a_q   <= pre_a_d;
    pre_b_q   <= pre_b_d;
  end

  assign stg[0] = '{valid: pre_valid_q, cmd: pre_cmd_q, a: pre_a_q, b: pre_b_q};

  for (genvar i = 0; i < NumRounds; i++) begin : g_cell
    feal4_round_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .stage_i   (stg[i]),
      .enc_key_i (key_q[i]),
      .dec_key_i (key_q[NumRounds-1-i]),
      .stage_o   (stg[i+1])
    );
  end

  always_comb begin
    if (stg[NumRounds].cmd == CMD_DECRYPT) begin
      out_hi_d = stg[NumRounds].a;
      out_lo_d = stg[NumRounds].a ^ stg[NumRounds].b;
    end else begin
      out_hi_d = stg[NumRounds].a ^ key_q[4];
      out_lo_d = stg[NumRounds].a ^ stg[NumRounds].b ^ key_q[5];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= stg[NumRounds].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    out_hi_q <= out_hi_d;
    out_lo_q <= out_lo_d;
  end

  assign done_o      = out_valid_q;
  assign result_hi_o = out_hi_q;
  assign result_lo_o = out_lo_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 done_o)
    else $error("transaction produced no result after six cycles");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 6))
    else $error("result without a transaction six cycles earlier");

  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(stg[0].valid, 5))
    else $error("result did not pass through the pre-mix stage");

endmodule

`default_nettype wire

### bench/feal4_checker.sv
`timescale 1ns / 100ps

module feal4_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        busy_i,
  input  wire logic        cmd_i,
  input  wire logic [31:0] block_hi_i,
  input  wire logic [31:0] block_lo_i,
  input  wire logic        done_i,
  input  wire logic [31:0] result_hi_i,
  input  wire logic [31:0] result_lo_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);
  import feal4_pkg::*;

  localparam int unsigned MaxReports = 40;

  typedef struct packed {
    logic [31:0] hi;
    logic [31:0] lo;
  } block_t;

  logic [31:0] subkey_q [NumKeys];
  block_t      expected_blocks [$];
  int unsigned errors = 0;

  function automatic logic [7:0] mix_byte(input logic [7:0] u, input logic [7:0] v,
                                          input logic carry);
    logic [7:0] sum;
    sum = u + v + {7'd0, carry};
    return {sum[5:0], sum[7:6]};
  endfunction

  function automatic logic [31:0] feal_f(input logic [31:0] w);
    logic [7:0] folded;
    logic [7:0] y0;
    logic [7:0] y1;
    logic [7:0] y2;
    logic [7:0] y3;
    folded = w[15:8] ^ w[7:0];
    y1 = mix_byte(w[31:24] ^ w[23:16], folded, 1'b1);
    y0 = mix_byte(w[31:24], y1, 1'b0);
    y2 = mix_byte(y1, folded, 1'b0);
    y3 = mix_byte(y2, w[7:0], 1'b1);
    return {y0, y1, y2, y3};
  endfunction

  function automatic block_t feal_encrypt(input logic [31:0] hi, input logic [31:0] lo);
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] held;
    block_t      res;
    left  = hi;
    right = hi ^ lo;
    for (int i = 0; i < NumRounds; i++) begin
      held  = right;
      right = left ^ feal_f(right ^ subkey_q[i]);
      left  = held;
    end
    res.hi = right ^ subkey_q[KEY_IDX_WHITE_L];
    res.lo = left ^ right ^ subkey_q[KEY_IDX_WHITE_R];
    return res;
  endfunction

  function automatic block_t feal_decrypt(input logic [31:0] hi, input logic [31:0] lo);
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] held;
    block_t      res;
    right = hi ^ subkey_q[KEY_IDX_WHITE_L];
    left  = right ^ lo ^ subkey_q[KEY_IDX_WHITE_R];
    for (int i = 0; i < NumRounds; i++) begin
      held  = left;
      left  = right ^ feal_f(left ^ subkey_q[NumRounds - 1 - i]);
      right = held;
    end
    res.hi = left;
    res.lo = right ^ left;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (errors < MaxReports) begin
      $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
    end
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    block_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumKeys; i++) begin
        subkey_q[i] = '0;
      end
      expected_blocks.delete();
    end else begin
      if (done_i === 1'b1) begin
        if (expected_blocks.size() == 0) begin
          report_mismatch("unexpected result transaction", result_hi_i, '0);
        end else begin
          want = expected_blocks.pop_front();
          if (result_hi_i !== want.hi) begin
            report_mismatch("result_hi", result_hi_i, want.hi);
          end
          if (result_lo_i !== want.lo) begin
            report_mismatch("result_lo", result_lo_i, want.lo);
          end
        end
      end else if (done_i !== 1'b0) begin
        report_mismatch("done strobe unknown", '0, '0);
      end
      if (cfg_we_i && cfg_idx_i < NumKeys) begin
        subkey_q[cfg_idx_i] = cfg_data_i;
      end
      if (start_i && !busy_i) begin
        if (cmd_i == CMD_ENCRYPT) begin
          expected_blocks.push_back(feal_encrypt(block_hi_i, block_lo_i));
        end else begin
          expected_blocks.push_back(feal_decrypt(block_hi_i, block_lo_i));
        end
      end
    end
    pending_o    <= expected_blocks.size();
    fail_count_o <= errors;
  end

endmodule

### bench/tb_feal4_block_cipher.sv
`timescale 1ns / 100ps

module tb_feal4_block_cipher;
  import feal4_pkg::*;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseItems  = 200;
  localparam int unsigned MaxGap      = 18;
  localparam int unsigned DrainCycles = 12;

  localparam logic [KeyIdxW-1:0] KEY_IDX_UNUSED_6 = 3'd6;
  localparam logic [KeyIdxW-1:0] KEY_IDX_UNUSED_7 = 3'd7;

  typedef enum {KEYS_ZERO, KEYS_ONES, KEYS_ALT, KEYS_RANDOM, KEYS_MIXED} key_style_e;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        start_i    = 1'b0;
  logic        cmd_i      = CMD_ENCRYPT;
  logic [31:0] block_hi_i = '0;
  logic [31:0] block_lo_i = '0;
  logic        cfg_we_i   = 1'b0;
  logic [2:0]  cfg_idx_i  = KEY_IDX_ROUND_0;
  logic [31:0] cfg_data_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [31:0] result_hi_o;
  logic [31:0] result_lo_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned encrypt_count = 0;
  int unsigned decrypt_count = 0;
  int unsigned key_sets = 1;
  int unsigned burst_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  feal4_block_cipher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .block_hi_i (block_hi_i),
    .block_lo_i (block_lo_i),
    .done_o     (done_o),
    .result_hi_o(result_hi_o),
    .result_lo_o(result_lo_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  feal4_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .cmd_i       (cmd_i),
    .block_hi_i  (block_hi_i),
    .block_lo_i  (block_lo_i),
    .done_i      (done_o),
    .result_hi_i (result_hi_o),
    .result_lo_i (result_lo_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("feal4_block_cipher verification failed");
      $finish;
    end
  end

  task automatic send_block(input logic cmd, input logic [31:0] hi, input logic [31:0] lo);
    start_i    <= 1'b1;
    cmd_i      <= cmd;
    block_hi_i <= hi;
    block_lo_i <= lo;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (cmd == CMD_ENCRYPT) begin
      encrypt_count++;
    end else begin
      decrypt_count++;
    end
  endtask

  task automatic idle_between();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 7) == 0) begin
      burst_left = $urandom_range(20, 60);
      gap = 0;
    end else begin
      gap = $urandom_range(0, MaxGap);
    end
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    case ($urandom_range(0, 15))
      0: begin
        w = '0;
      end
      1: begin
        w = '1;
      end
      default: begin
        w = $urandom();
      end
    endcase
    return w;
  endfunction

  task automatic rekey(input key_style_e style);
    logic [31:0] value;
    for (int i = 0; i < NumKeys; i++) begin
      case (style)
        KEYS_ZERO: begin
          value = '0;
        end
        KEYS_ONES: begin
          value = '1;
        end
        KEYS_ALT: begin
          value = (i % 2 == 0) ? 32'hAAAA_AAAA : 32'h5555_5555;
        end
        KEYS_MIXED: begin
          value = pick_word();
        end
        default: begin
          value = $urandom();
        end
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= i[KeyIdxW-1:0];
      cfg_data_i <= value;
      @(posedge clk_i);
    end
    cfg_idx_i  <= ($urandom_range(0, 1) == 0) ? KEY_IDX_UNUSED_6 : KEY_IDX_UNUSED_7;
    cfg_data_i <= $urandom();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    key_sets++;
  endtask

  initial begin
    logic cmd;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    send_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
    drain();
    rekey(KEYS_ONES);
    send_block(CMD_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
    send_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_block(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
    send_block(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000);
    drain();
    rekey(KEYS_ALT);
    send_block(CMD_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF);
    send_block(CMD_DECRYPT, 32'h89AB_CDEF, 32'h0123_4567);
    send_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_block(CMD_DECRYPT, 32'h0000_0000, 32'hFFFF_FFFF);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      rekey((p % 2 == 0) ? KEYS_RANDOM : KEYS_MIXED);
      for (int n = 0; n < PhaseItems; n++) begin
        cmd = ($urandom_range(0, 1) == 0) ? CMD_ENCRYPT : CMD_DECRYPT;
        send_block(cmd, pick_word(), pick_word());
        if (p == 2 && n == PhaseItems / 2) begin
          drain();
        end else begin
          idle_between();
        end
      end
      drain();
    end
    rekey(KEYS_ZERO);
    send_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000);
    drain();

    $display("Covered %0d encryptions and %0d decryptions under %0d subkey settings,",
             encrypt_count, decrypt_count, key_sets);
    $display("with back-to-back bursts, random gaps and full drains between settings.");
    if (fail_count == 0) begin
      $display("feal4_block_cipher verification clean");
    end else begin
      $display("feal4_block_cipher verification failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/feal4_pkg.sv
hdl/feal4_round_cell.sv
hdl/feal4_block_cipher.sv
bench/feal4_checker.sv
bench/tb_feal4_block_cipher.sv
